FILE: hw/rtl/infix_to_postfix_converter_core_macros.svh
// assertion macros used by the checker file of the infix to postfix core
// each macro expects clk and rst_n in scope

`ifndef INFIX_TO_POSTFIX_CONVERTER_CORE_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_CORE_MACROS_SVH

// same-cycle implication
`define ITP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ITP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/itp_pkg.sv
// shared types, constants and lookup functions for the infix to postfix core
// no dependencies

package itp_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CODE_W      = 3;
  localparam int CHAR_W      = 8;

  // operator codes as held on the stack
  localparam logic [CODE_W-1:0] CODE_LPAREN = 3'd0;
  localparam logic [CODE_W-1:0] CODE_PLUS   = 3'd1;
  localparam logic [CODE_W-1:0] CODE_MINUS  = 3'd2;
  localparam logic [CODE_W-1:0] CODE_MUL    = 3'd3;
  localparam logic [CODE_W-1:0] CODE_DIV    = 3'd4;
  localparam logic [CODE_W-1:0] CODE_POW    = 3'd5;

  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_MUL    = 8'h2a;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_DIV    = 8'h2f;
  localparam logic [CHAR_W-1:0] CH_POW    = 8'h5e;
  localparam logic [CHAR_W-1:0] CH_DIG_LO = 8'h30;
  localparam logic [CHAR_W-1:0] CH_DIG_HI = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UC_LO  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UC_HI  = 8'h5a;
  localparam logic [CHAR_W-1:0] CH_LC_LO  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LC_HI  = 8'h7a;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_TOPWAIT,
    ST_POPCHK,
    ST_EMIT,
    ST_LASTCHK,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    MODE_CLOSE,
    MODE_OP,
    MODE_FLUSH
  } mode_t;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic [CODE_W-1:0] wcode;
  } stk_cmd_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [CODE_W-1:0] top;
  } stk_stat_t;

  function automatic logic [CHAR_W-1:0] code_char(input logic [CODE_W-1:0] code);
    logic [CHAR_W-1:0] ch;
    case (code)
      CODE_LPAREN: ch = CH_LPAREN;
      CODE_PLUS:   ch = CH_PLUS;
      CODE_MINUS:  ch = CH_MINUS;
      CODE_MUL:    ch = CH_MUL;
      CODE_DIV:    ch = CH_DIV;
      CODE_POW:    ch = CH_POW;
      default:     ch = CH_NUL;
    endcase
    return ch;
  endfunction

  function automatic logic [1:0] code_prec(input logic [CODE_W-1:0] code);
    logic [1:0] p;
    case (code)
      CODE_PLUS, CODE_MINUS: p = 2'd1;
      CODE_MUL, CODE_DIV:    p = 2'd2;
      CODE_POW:              p = 2'd3;
      default:               p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic logic [CODE_W-1:0] char_code(input logic [CHAR_W-1:0] ch);
    logic [CODE_W-1:0] code;
    case (ch)
      CH_PLUS:  code = CODE_PLUS;
      CH_MINUS: code = CODE_MINUS;
      CH_MUL:   code = CODE_MUL;
      CH_DIV:   code = CODE_DIV;
      CH_POW:   code = CODE_POW;
      default:  code = CODE_LPAREN;
    endcase
    return code;
  endfunction

endpackage

FILE: hw/rtl/itp_ram.sv
// generic single write port ram with one registered read port
// no dependencies

module itp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

FILE: hw/rtl/itp_stack.sv
// operator stack: fill count plus ram, top entry comes out of the registered read
// depends on itp_pkg and itp_ram

module itp_stack (
  input  logic               clk,
  input  logic               rst_n,
  input  itp_pkg::stk_cmd_t  cmd,
  output itp_pkg::stk_stat_t stat
);

  logic [itp_pkg::CNT_W-1:0]  count_r;
  logic [itp_pkg::CNT_W-1:0]  count_nxt;
  logic [itp_pkg::CNT_W-1:0]  count_dec;
  logic [itp_pkg::CODE_W-1:0] top_code;
  logic                       full;
  logic                       wr_en;

  assign full      = (count_r == itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH));
  assign count_dec = count_r - itp_pkg::CNT_W'(1);
  assign wr_en     = cmd.push && !full;

  // top entry read is registered, so it is valid in the cycle after the count settles
  itp_ram #(
    .WIDTH (itp_pkg::CODE_W),
    .DEPTH (itp_pkg::STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count_r[itp_pkg::ADDR_W-1:0]),
    .wdata (cmd.wcode),
    .raddr (count_dec[itp_pkg::ADDR_W-1:0]),
    .rdata (top_code)
  );

  always_comb begin
    count_nxt = count_r;
    if (wr_en) begin
      count_nxt = count_r + itp_pkg::CNT_W'(1);
    end else if (cmd.pop && (count_r != '0)) begin
      count_nxt = count_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign stat.full  = full;
  assign stat.empty = (count_r == '0);
  assign stat.top   = top_code;

endmodule

FILE: hw/rtl/infix_to_postfix_converter_core.sv
// Infix to postfix converter (shunting-yard). One input beat carries one
// character; the core drops in_ready until that character is fully handled.
// A letter or digit passes dispatch, emit, last check and done; an ignored
// character or '(' skips emit. Each operator popped off the stack adds a
// wait for the registered stack ram read, a precedence compare and the
// hand-off of the result; a ')' or a last character unwinds the stack that
// way. One result is held back so end_of_run can land on the final beat of
// a run; results leave through an output register, so the next character is
// taken while a result still waits on out_ready. The stack holds
// itp_pkg::STACK_DEPTH entries; a push onto a full stack is dropped and the
// beats of that character that leave after the drop carry overflow.
// depends on itp_pkg and itp_stack

module infix_to_postfix_converter_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_is_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_char_valid,
  output logic       out_end_of_run,
  output logic       out_overflow
);

  itp_pkg::state_t state_r, state_nxt;
  itp_pkg::mode_t  mode_r, mode_nxt;

  logic [itp_pkg::CHAR_W-1:0] char_r, char_nxt;
  logic                       last_r, last_nxt;
  logic [itp_pkg::CODE_W-1:0] code_r, code_nxt;
  logic                       ovf_r, ovf_nxt;
  logic                       ret_top_r, ret_top_nxt;
  logic [itp_pkg::CHAR_W-1:0] new_char_r, new_char_nxt;
  logic                       pend_v_r, pend_v_nxt;
  logic [itp_pkg::CHAR_W-1:0] pend_char_r, pend_char_nxt;

  logic                       oval_r, oval_nxt;
  logic [itp_pkg::CHAR_W-1:0] ochar_r, ochar_nxt;
  logic                       ocv_r, ocv_nxt;
  logic                       oend_r, oend_nxt;
  logic                       oovf_r, oovf_nxt;

  itp_pkg::stk_cmd_t  stk_cmd;
  itp_pkg::stk_stat_t stk_stat;

  logic is_alnum, is_lp, is_rp, is_op;
  logic do_pop, pop_emits, out_free, emit_go, need_send;

  itp_stack u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (stk_cmd),
    .stat  (stk_stat)
  );

  always_comb begin
    is_alnum = char_r inside {[itp_pkg::CH_DIG_LO:itp_pkg::CH_DIG_HI],
                              [itp_pkg::CH_UC_LO:itp_pkg::CH_UC_HI],
                              [itp_pkg::CH_LC_LO:itp_pkg::CH_LC_HI]};
    is_op    = char_r inside {itp_pkg::CH_PLUS, itp_pkg::CH_MINUS, itp_pkg::CH_MUL,
                              itp_pkg::CH_DIV, itp_pkg::CH_POW};
  end

  assign is_lp = (char_r == itp_pkg::CH_LPAREN);
  assign is_rp = (char_r == itp_pkg::CH_RPAREN);

  // the one compare unit: for an operator stop at '(' or at a lower precedence operator, else pop while not empty
  assign do_pop = !stk_stat.empty &&
                  ((mode_r != itp_pkg::MODE_OP) ||
                   ((stk_stat.top != itp_pkg::CODE_LPAREN) &&
                    (itp_pkg::code_prec(stk_stat.top) >= itp_pkg::code_prec(code_r))));
  assign pop_emits = do_pop &&
                     !((mode_r == itp_pkg::MODE_CLOSE) &&
                       (stk_stat.top == itp_pkg::CODE_LPAREN));

  assign out_free  = !oval_r || out_ready;
  assign emit_go   = !pend_v_r || out_free;
  assign need_send = pend_v_r || last_r || ovf_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      itp_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = itp_pkg::ST_DISPATCH;
        end
      end
      itp_pkg::ST_DISPATCH: begin
        if (is_alnum) begin
          state_nxt = itp_pkg::ST_EMIT;
        end else if (is_rp || is_op) begin
          state_nxt = itp_pkg::ST_TOPWAIT;
        end else begin
          state_nxt = itp_pkg::ST_LASTCHK;
        end
      end
      itp_pkg::ST_TOPWAIT: state_nxt = itp_pkg::ST_POPCHK;
      itp_pkg::ST_POPCHK: begin
        if (pop_emits) begin
          state_nxt = itp_pkg::ST_EMIT;
        end else if (do_pop || (mode_r != itp_pkg::MODE_FLUSH)) begin
          state_nxt = itp_pkg::ST_LASTCHK;
        end else begin
          state_nxt = itp_pkg::ST_DONE;
        end
      end
      itp_pkg::ST_EMIT: begin
        if (emit_go) begin
          if (ret_top_r) begin
            state_nxt = itp_pkg::ST_TOPWAIT;
          end else begin
            state_nxt = itp_pkg::ST_LASTCHK;
          end
        end
      end
      itp_pkg::ST_LASTCHK: begin
        if (last_r) begin
          state_nxt = itp_pkg::ST_TOPWAIT;
        end else begin
          state_nxt = itp_pkg::ST_DONE;
        end
      end
      itp_pkg::ST_DONE: begin
        if (!need_send || out_free) begin
          state_nxt = itp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = itp_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    mode_nxt      = mode_r;
    char_nxt      = char_r;
    last_nxt      = last_r;
    code_nxt      = code_r;
    ovf_nxt       = ovf_r;
    ret_top_nxt   = ret_top_r;
    new_char_nxt  = new_char_r;
    pend_v_nxt    = pend_v_r;
    pend_char_nxt = pend_char_r;
    stk_cmd       = '0;
    oval_nxt      = oval_r && !out_ready;
    ochar_nxt     = ochar_r;
    ocv_nxt       = ocv_r;
    oend_nxt      = oend_r;
    oovf_nxt      = oovf_r;
    case (state_r)
      itp_pkg::ST_IDLE: begin
        if (in_valid) begin
          char_nxt = in_char;
          last_nxt = in_is_last;
          ovf_nxt  = 1'b0;
        end
      end
      itp_pkg::ST_DISPATCH: begin
        code_nxt = itp_pkg::char_code(char_r);
        if (is_alnum) begin
          new_char_nxt = char_r;
          ret_top_nxt  = 1'b0;
        end else if (is_lp) begin
          if (stk_stat.full) begin
            ovf_nxt = 1'b1;
          end else begin
            stk_cmd.push  = 1'b1;
            stk_cmd.wcode = itp_pkg::CODE_LPAREN;
          end
        end else if (is_rp) begin
          mode_nxt = itp_pkg::MODE_CLOSE;
        end else if (is_op) begin
          mode_nxt = itp_pkg::MODE_OP;
        end
      end
      itp_pkg::ST_POPCHK: begin
        if (do_pop) begin
          stk_cmd.pop = 1'b1;
          if (pop_emits) begin
            new_char_nxt = itp_pkg::code_char(stk_stat.top);
            ret_top_nxt  = 1'b1;
          end
        end else if (mode_r == itp_pkg::MODE_OP) begin
          if (stk_stat.full) begin
            ovf_nxt = 1'b1;
          end else begin
            stk_cmd.push  = 1'b1;
            stk_cmd.wcode = code_r;
          end
        end
      end
      itp_pkg::ST_EMIT: begin
        if (emit_go) begin
          // held result goes out now that a later one exists
          if (pend_v_r) begin
            oval_nxt  = 1'b1;
            ochar_nxt = pend_char_r;
            ocv_nxt   = 1'b1;
            oend_nxt  = 1'b0;
            oovf_nxt  = ovf_r;
          end
          pend_v_nxt    = 1'b1;
          pend_char_nxt = new_char_r;
        end
      end
      itp_pkg::ST_LASTCHK: begin
        if (last_r) begin
          mode_nxt = itp_pkg::MODE_FLUSH;
        end
      end
      itp_pkg::ST_DONE: begin
        if (need_send && out_free) begin
          oval_nxt   = 1'b1;
          ochar_nxt  = pend_v_r ? pend_char_r : itp_pkg::CH_NUL;
          ocv_nxt    = pend_v_r;
          oend_nxt   = last_r;
          oovf_nxt   = ovf_r;
          pend_v_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= itp_pkg::ST_IDLE;
      pend_v_r <= 1'b0;
      oval_r   <= 1'b0;
      ovf_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pend_v_r <= pend_v_nxt;
      oval_r   <= oval_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    char_r      <= char_nxt;
    last_r      <= last_nxt;
    code_r      <= code_nxt;
    ret_top_r   <= ret_top_nxt;
    new_char_r  <= new_char_nxt;
    pend_char_r <= pend_char_nxt;
    ochar_r     <= ochar_nxt;
    ocv_r       <= ocv_nxt;
    oend_r      <= oend_nxt;
    oovf_r      <= oovf_nxt;
  end

  assign in_ready       = (state_r == itp_pkg::ST_IDLE);
  assign out_valid      = oval_r;
  assign out_char       = ochar_r;
  assign out_char_valid = ocv_r;
  assign out_end_of_run = oend_r;
  assign out_overflow   = oovf_r;

endmodule

FILE: hw/rtl/itp_checker.sv
// port level checks for the infix to postfix core, bound to the top level
// depends on infix_to_postfix_converter_core_macros.svh

`include "infix_to_postfix_converter_core_macros.svh"

module itp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       out_char_valid,
  input logic       out_end_of_run,
  input logic       out_overflow
);

  // a stalled result beat stays put
  `ITP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_char), "result beat dropped or changed while stalled")

  // one character at a time: no accept right after an accept
  `ITP_ASSERT_NEXT(a_in_one_at_a_time, in_valid && in_ready, !in_ready, "input taken while previous character still busy")

  // a bare marker carries no character
  `ITP_ASSERT_NOW(a_bare_zero, out_valid && !out_char_valid, out_char == 8'h00, "bare marker with nonzero character")

  // a bare marker only closes a run or flags a dropped push
  `ITP_ASSERT_NOW(a_bare_reason, out_valid && !out_char_valid, out_end_of_run || out_overflow, "bare marker without end or overflow")

endmodule

bind infix_to_postfix_converter_core itp_checker u_itp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_char       (out_char),
  .out_char_valid (out_char_valid),
  .out_end_of_run (out_end_of_run),
  .out_overflow   (out_overflow)
);
